// ----- hw/rtl/msp_rx_pkg.sv -----
package msp_rx_pkg;

   // frame bytes
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_X      = 8'h58;
   localparam logic [7:0] CHAR_LT     = 8'h3C;
   localparam logic [7:0] CHAR_GT     = 8'h3E;

   // crc-8 dvb-s2
   localparam logic [7:0] CRC_POLY    = 8'hD5;
   localparam logic [7:0] CRC_TOP_BIT = 8'h80;

   localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1024;

   // csr map
   localparam int CSR_ADDR_WIDTH = 3;
   localparam logic [0:0] CSR_IDX_MAX_PAYLOAD = 1'b0;

   // parser phase
   localparam logic [2:0] PH_HUNT     = 3'd0;
   localparam logic [2:0] PH_WANT_X   = 3'd1;
   localparam logic [2:0] PH_WANT_DIR = 3'd2;
   localparam logic [2:0] PH_HEADER   = 3'd3;
   localparam logic [2:0] PH_PAYLOAD  = 3'd4;
   localparam logic [2:0] PH_CRC      = 3'd5;

   // header byte positions
   localparam logic [2:0] HDR_FLAGS  = 3'd0;
   localparam logic [2:0] HDR_CMD_LO = 3'd1;
   localparam logic [2:0] HDR_CMD_HI = 3'd2;
   localparam logic [2:0] HDR_LEN_LO = 3'd3;
   localparam logic [2:0] HDR_LEN_HI = 3'd4;

   // event codes
   localparam logic [2:0] EV_IGNORED  = 3'd0;
   localparam logic [2:0] EV_PREAMBLE = 3'd1;
   localparam logic [2:0] EV_HEADER   = 3'd2;
   localparam logic [2:0] EV_PAYLOAD  = 3'd3;
   localparam logic [2:0] EV_OK       = 3'd4;
   localparam logic [2:0] EV_CRC_BAD  = 3'd5;
   localparam logic [2:0] EV_OVERSIZE = 3'd6;
   localparam logic [2:0] EV_BAD_PRE  = 3'd7;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [7:0]  payload_byte;
      logic [15:0] payload_index;
      logic [15:0] command;
      logic [7:0]  frame_flags;
      logic [15:0] payload_length;
      logic        direction;
      logic [7:0]  frame_crc;
   } result_type;

   // one byte through the crc, msb first
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_TOP_BIT) != 8'd0) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ----- hw/rtl/msp_v2_frame_receiver.sv -----
// msp v2 frame receiver: one byte word in, one result word out per byte
// each result is registered before rsp_valid presents it; if the result register is held, it waits in the skid register
// throughput: one byte per cycle while req_stall is low; the crc update is an unrolled eight-step xor network
// result register plus skid register keep input flowing; req_stall rises when both are full
// reset (synchronous, active high): parser hunts for '$', captured fields and crc clear,
// max_payload returns to 1024, output stage empties
module msp_v2_frame_receiver
   import msp_rx_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // byte input
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_data_byte,
   // result output
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [2:0]                rsp_event_res,
   output logic [7:0]                rsp_payload_byte,
   output logic [15:0]               rsp_payload_index,
   output logic [15:0]               rsp_command,
   output logic [7:0]                rsp_frame_flags,
   output logic [15:0]               rsp_payload_length,
   output logic                      rsp_direction,
   output logic [7:0]                rsp_frame_crc,
   // apb register port
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);

   // ---------------------------------------------------------------
   // register port: max_payload at byte address 0
   // ---------------------------------------------------------------
   logic [15:0] max_payload_ff;
   logic        csr_wr;
   logic [0:0]  csr_idx;

   assign pready  = 1'b1;
   assign csr_idx = paddr[CSR_ADDR_WIDTH-1:2];
   assign csr_wr  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= MAX_PAYLOAD_RESET;
      end else if (csr_wr && (csr_idx == CSR_IDX_MAX_PAYLOAD)) begin
         max_payload_ff <= pwdata[15:0];
      end
   end

   always_comb begin
      prdata = 32'd0;
      if (csr_idx == CSR_IDX_MAX_PAYLOAD) begin
         prdata = {16'd0, max_payload_ff};
      end
   end

   // ---------------------------------------------------------------
   // parser state
   // ---------------------------------------------------------------
   logic [2:0]  phase_ff,         phase_in;
   logic [2:0]  header_count_ff,  header_count_in;
   logic [15:0] payload_count_ff, payload_count_in;
   logic [7:0]  crc_ff,           crc_in;
   logic [7:0]  flags_ff,         flags_in;
   logic [15:0] command_ff,       command_in;
   logic [15:0] length_ff,        length_in;
   logic        direction_ff,     direction_in;

   result_type  res_new;
   logic [7:0]  c;
   logic [7:0]  crc_step;
   logic [15:0] count_inc;
   logic        accept;

   assign c         = req_data_byte;
   assign crc_step  = crc8_byte(crc_ff, c);
   assign count_inc = payload_count_ff + 16'd1;

   always_comb begin
      phase_in         = phase_ff;
      header_count_in  = header_count_ff;
      payload_count_in = payload_count_ff;
      crc_in           = crc_ff;
      flags_in         = flags_ff;
      command_in       = command_ff;
      length_in        = length_ff;
      direction_in     = direction_ff;
      res_new          = '0;
      res_new.event_res = EV_IGNORED;

      case (phase_ff)
         PH_WANT_X: begin
            if (c == CHAR_X) begin
               res_new.event_res = EV_PREAMBLE;
               phase_in          = PH_WANT_DIR;
            end else begin
               res_new.event_res = EV_BAD_PRE;
               phase_in          = PH_HUNT;
            end
         end
         PH_WANT_DIR: begin
            if ((c == CHAR_LT) || (c == CHAR_GT)) begin
               res_new.event_res = EV_PREAMBLE;
               direction_in      = (c == CHAR_GT);
               crc_in            = 8'd0;
               header_count_in   = 3'd0;
               payload_count_in  = 16'd0;
               phase_in          = PH_HEADER;
            end else begin
               res_new.event_res = EV_BAD_PRE;
               phase_in          = PH_HUNT;
            end
         end
         PH_HEADER: begin
            crc_in            = crc_step;
            res_new.event_res = EV_HEADER;
            case (header_count_ff)
               HDR_FLAGS:  flags_in   = c;
               HDR_CMD_LO: command_in = {command_ff[15:8], c};
               HDR_CMD_HI: command_in = {c, command_ff[7:0]};
               HDR_LEN_LO: length_in  = {length_ff[15:8], c};
               default:    length_in  = {c, length_ff[7:0]};
            endcase
            if (header_count_ff >= HDR_LEN_HI) begin
               // header complete: size check decides where to go
               header_count_in  = 3'd0;
               payload_count_in = 16'd0;
               if (length_in > max_payload_ff) begin
                  res_new.event_res = EV_OVERSIZE;
                  phase_in          = PH_HUNT;
               end else if (length_in != 16'd0) begin
                  phase_in = PH_PAYLOAD;
               end else begin
                  phase_in = PH_CRC;
               end
            end else begin
               header_count_in = header_count_ff + 3'd1;
            end
         end
         PH_PAYLOAD: begin
            crc_in                = crc_step;
            res_new.event_res     = EV_PAYLOAD;
            res_new.payload_byte  = c;
            res_new.payload_index = payload_count_ff;
            payload_count_in      = count_inc;
            if (count_inc == length_ff) begin
               phase_in = PH_CRC;
            end
         end
         PH_CRC: begin
            res_new.event_res = (c == crc_ff) ? EV_OK : EV_CRC_BAD;
            phase_in          = PH_HUNT;
         end
         default: begin
            // hunting, also covers unused phase codes
            if (c == CHAR_DOLLAR) begin
               res_new.event_res = EV_PREAMBLE;
               phase_in          = PH_WANT_X;
            end else begin
               res_new.event_res = EV_IGNORED;
               phase_in          = PH_HUNT;
            end
         end
      endcase

      // captured fields as they stand after this byte
      res_new.command        = command_in;
      res_new.frame_flags    = flags_in;
      res_new.payload_length = length_in;
      res_new.direction      = direction_in;
      res_new.frame_crc      = crc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HUNT;
         header_count_ff  <= 3'd0;
         payload_count_ff <= 16'd0;
         crc_ff           <= 8'd0;
         flags_ff         <= 8'd0;
         command_ff       <= 16'd0;
         length_ff        <= 16'd0;
         direction_ff     <= 1'b0;
      end else if (accept) begin
         phase_ff         <= phase_in;
         header_count_ff  <= header_count_in;
         payload_count_ff <= payload_count_in;
         crc_ff           <= crc_in;
         flags_ff         <= flags_in;
         command_ff       <= command_in;
         length_ff        <= length_in;
         direction_ff     <= direction_in;
      end
   end

   // ---------------------------------------------------------------
   // output stage: result register with a skid register behind it
   // ---------------------------------------------------------------
   logic       out_valid_ff;
   logic       skid_valid_ff;
   result_type out_ff;
   result_type skid_ff;
   logic       out_free;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   // result register can load when empty or its word is taken now
   assign out_free  = !out_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_ff <= skid_valid_ff ? skid_ff : res_new;
      end
      if (!out_free && accept) begin
         skid_ff <= res_new;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_event_res      = out_ff.event_res;
   assign rsp_payload_byte   = out_ff.payload_byte;
   assign rsp_payload_index  = out_ff.payload_index;
   assign rsp_command        = out_ff.command;
   assign rsp_frame_flags    = out_ff.frame_flags;
   assign rsp_payload_length = out_ff.payload_length;
   assign rsp_direction      = out_ff.direction;
   assign rsp_frame_crc      = out_ff.frame_crc;

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
   // skid only fills behind a held result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word present without a result word");

   // every accepted byte leaves a result word pending next cycle
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> out_valid_ff)
      else $error("accepted byte produced no result word");

   // a payload word's index stays below the captured size
   a_payload_index_range: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_ff.event_res == EV_PAYLOAD))
         |-> (out_ff.payload_index < out_ff.payload_length))
      else $error("payload index beyond payload length");

   // header counter never passes the last header byte
   a_header_count_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HEADER) |-> (header_count_ff <= HDR_LEN_HI))
      else $error("header count out of range");

endmodule
